// ===== rtl/core/cbms_pkg.sv =====
// ----------------------------------------------------------------------------
// cbms_pkg
// Field widths, register indexes and reset values for the Bezier motion core.
// ----------------------------------------------------------------------------
package cbms_pkg;

  localparam int COORD_W     = 32;
  localparam int FT_W        = 20;
  localparam int DUR_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 128;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTL1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTL2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd4;

  // One second in unsigned Q16.16.
  localparam dur_t DUR_RESET = 32'd65536;

endpackage

// ===== rtl/core/cubic_bezier_motion_step_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_motion_step_core
// Moves a point along a cubic Bezier path, one frame tick per input item.
//
// A tick that stays on the path goes from acceptance through a restoring
// divider that forms t one quotient bit per cycle and through six passes of a
// two-lane shift-add multiplier that consumes one multiplier bit per cycle
// (t*t and u*u, the two middle weights, the end weight, then the three control
// terms with x and y side by side) before its result is offered. A tick past
// the end of the move skips the divider and the multiplier, and a stop item
// starts no work. The core works on one item at a time and takes the next one
// as soon as it is back in idle, even while the previous result still sits in
// the output register. Any write to a defined register restarts the move at
// the start position.
// ----------------------------------------------------------------------------
module cubic_bezier_motion_step_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [19:0] frame_time, [23:20] zero
  input  logic [cbms_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] position_x, [63:32] position_y, [95:64] velocity_x,
  // [127:96] velocity_y
  output logic [cbms_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] reached
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [cbms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbms_pkg::CFG_W-1:0]          cfg_data
);
  import cbms_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int N   = F + 1;
  localparam int CW  = $clog2(N);
  localparam int MCW = (F + 3 > COORD_W) ? F + 3 : COORD_W;
  localparam int ACW = MCW + N + 1;

  localparam logic [N-1:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [ACW-1:0] HALF = {{(ACW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [CW-1:0]  LAST = CW'(N - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OFFS  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [2:0] P_SQ  = 3'd0;
  localparam logic [2:0] P_W12 = 3'd1;
  localparam logic [2:0] P_W3  = 3'd2;
  localparam logic [2:0] P_CB  = 3'd3;
  localparam logic [2:0] P_CC  = 3'd4;
  localparam logic [2:0] P_CD  = 3'd5;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [2:0]    pass_r, pass_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          halted_r, halted_nxt;
  dur_t          elapsed_r, elapsed_nxt;
  coord_t        cur_x_r, cur_x_nxt;
  coord_t        cur_y_r, cur_y_nxt;
  cfg_word_t     start_r, start_nxt;
  cfg_word_t     ctl1_r, ctl1_nxt;
  cfg_word_t     ctl2_r, ctl2_nxt;
  cfg_word_t     end_r, end_nxt;
  dur_t          dur_r, dur_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;

  // Datapath
  logic [DUR_W:0]           rem_r, rem_nxt;
  logic [N-1:0]             t_r, t_nxt;
  logic [N-1:0]             u_r, u_nxt;
  logic [N-1:0]             tt_r, tt_nxt;
  logic [N-1:0]             w1_r, w1_nxt;
  logic [N-1:0]             w2_r, w2_nxt;
  logic [N-1:0]             w3_r, w3_nxt;
  logic [ACW-1:0]           acc_r [2];
  logic [ACW-1:0]           acc_nxt [2];
  logic [ACW-1:0]           mc_r [2];
  logic [ACW-1:0]           mc_nxt [2];
  logic [N-1:0]             mlt_r [2];
  logic [N-1:0]             mlt_nxt [2];
  coord_t                   new_x_r, new_x_nxt;
  coord_t                   new_y_r, new_y_nxt;
  logic                     reach_r, reach_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic                     out_user_r, out_user_nxt;

  // Combinational helpers
  logic           in_acc;
  logic [DUR_W:0] elapsed_sum;
  dur_t           elapsed_sat;
  dur_t           dur_eff;
  logic [DUR_W+1:0] trial;
  logic           qbit;
  logic [DUR_W:0] rem_sel;
  logic [N-1:0]   u_val;
  logic [N-1:0]   sq_a;
  logic [N-1:0]   sq_b;
  logic [ACW-1:0] tt_ext;
  logic [ACW-1:0] uu_ext;
  logic [ACW-1:0] tt3;
  logic [ACW-1:0] uu3;
  logic           restart;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign elapsed_sum = {1'b0, elapsed_r} + (DUR_W + 1)'(in_tdata[FT_W-1:0]);
  assign elapsed_sat = elapsed_sum[DUR_W] ? {DUR_W{1'b1}} : elapsed_sum[DUR_W-1:0];
  // A zero duration behaves like the smallest nonzero one.
  assign dur_eff     = (dur_r == '0) ? DUR_W'(1) : dur_r;

  // Restoring division step: one quotient bit of t per cycle.
  assign trial   = {1'b0, rem_r} - {2'b00, dur_eff};
  assign qbit    = !trial[DUR_W+1];
  assign rem_sel = qbit ? trial[DUR_W:0] : rem_r;

  assign u_val  = ONE - t_r;
  assign sq_a   = acc_r[0][F +: N];
  assign sq_b   = acc_r[1][F +: N];
  assign tt_ext = {{(ACW-N){1'b0}}, sq_a};
  assign uu_ext = {{(ACW-N){1'b0}}, sq_b};
  assign tt3    = (tt_ext << 1) + tt_ext;
  assign uu3    = (uu_ext << 1) + uu_ext;

  assign restart = cfg_we && (cfg_index <= REG_DURATION);

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    cnt_nxt        = cnt_r;
    halted_nxt     = halted_r;
    elapsed_nxt    = elapsed_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    start_nxt      = start_r;
    ctl1_nxt       = ctl1_r;
    ctl2_nxt       = ctl2_r;
    end_nxt        = end_r;
    dur_nxt        = dur_r;
    out_tvalid_nxt = out_tvalid_r;
    rem_nxt        = rem_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    tt_nxt         = tt_r;
    w1_nxt         = w1_r;
    w2_nxt         = w2_r;
    w3_nxt         = w3_r;
    acc_nxt        = acc_r;
    mc_nxt         = mc_r;
    mlt_nxt        = mlt_r;
    new_x_nxt      = new_x_r;
    new_y_nxt      = new_y_r;
    reach_nxt      = reach_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && !halted_r) begin
          if (in_tuser) begin
            halted_nxt = 1'b1;
          end else begin
            elapsed_nxt = elapsed_sat;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (elapsed_r > dur_eff) begin
          // Past the end: hold the position, so the velocity comes out zero.
          new_x_nxt = cur_x_r;
          new_y_nxt = cur_y_r;
          reach_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rem_nxt   = {1'b0, elapsed_r};
          cnt_nxt   = '0;
          reach_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        t_nxt   = {t_r[N-2:0], qbit};
        rem_nxt = {rem_sel[DUR_W-1:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          pass_nxt  = P_SQ;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
        case (pass_r)
          P_SQ: begin
            u_nxt      = u_val;
            mlt_nxt[0] = t_r;
            mc_nxt[0]  = {{(ACW-N){1'b0}}, t_r};
            mlt_nxt[1] = u_val;
            mc_nxt[1]  = {{(ACW-N){1'b0}}, u_val};
            acc_nxt[0] = HALF;
            acc_nxt[1] = HALF;
          end
          P_W12: begin
            tt_nxt     = sq_a;
            mlt_nxt[0] = t_r;
            mc_nxt[0]  = uu3;
            mlt_nxt[1] = u_r;
            mc_nxt[1]  = tt3;
            acc_nxt[0] = HALF;
            acc_nxt[1] = HALF;
          end
          P_W3: begin
            w1_nxt     = sq_a;
            w2_nxt     = sq_b;
            mlt_nxt[0] = t_r;
            mc_nxt[0]  = {{(ACW-N){1'b0}}, tt_r};
            mlt_nxt[1] = '0;
            mc_nxt[1]  = '0;
            acc_nxt[0] = HALF;
          end
          P_CB: begin
            // The rounding constant seeds the sum of the three control terms.
            w3_nxt     = sq_a;
            mlt_nxt[0] = w1_r;
            mlt_nxt[1] = w1_r;
            mc_nxt[0]  = {{(ACW-COORD_W){ctl1_r[31]}}, ctl1_r[31:0]};
            mc_nxt[1]  = {{(ACW-COORD_W){ctl1_r[63]}}, ctl1_r[63:32]};
            acc_nxt[0] = HALF;
            acc_nxt[1] = HALF;
          end
          P_CC: begin
            mlt_nxt[0] = w2_r;
            mlt_nxt[1] = w2_r;
            mc_nxt[0]  = {{(ACW-COORD_W){ctl2_r[31]}}, ctl2_r[31:0]};
            mc_nxt[1]  = {{(ACW-COORD_W){ctl2_r[63]}}, ctl2_r[63:32]};
          end
          P_CD: begin
            mlt_nxt[0] = w3_r;
            mlt_nxt[1] = w3_r;
            mc_nxt[0]  = {{(ACW-COORD_W){end_r[31]}}, end_r[31:0]};
            mc_nxt[1]  = {{(ACW-COORD_W){end_r[63]}}, end_r[63:32]};
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        for (int l = 0; l < 2; l++) begin
          acc_nxt[l] = acc_r[l] + (mlt_r[l][0] ? mc_r[l] : '0);
          mc_nxt[l]  = mc_r[l] << 1;
          mlt_nxt[l] = mlt_r[l] >> 1;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          if (pass_r == P_CD) begin
            state_nxt = S_OFFS;
          end else begin
            pass_nxt  = pass_r + 3'd1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_OFFS: begin
        // Arithmetic shift by F of the rounded sum, then add the start point.
        new_x_nxt = start_r[31:0] + acc_r[0][F +: COORD_W];
        new_y_nxt = start_r[63:32] + acc_r[1][F +: COORD_W];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {new_y_r - cur_y_r, new_x_r - cur_x_r, new_y_r, new_x_r};
          out_user_nxt   = reach_r;
          out_tvalid_nxt = 1'b1;
          cur_x_nxt      = new_x_r;
          cur_y_nxt      = new_y_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (restart) begin
      case (cfg_index)
        REG_START:    start_nxt = cfg_data;
        REG_CTL1:     ctl1_nxt  = cfg_data;
        REG_CTL2:     ctl2_nxt  = cfg_data;
        REG_END:      end_nxt   = cfg_data;
        REG_DURATION: dur_nxt   = cfg_data[DUR_W-1:0];
        default:      ;
      endcase
      elapsed_nxt = '0;
      halted_nxt  = 1'b0;
      cur_x_nxt   = start_nxt[31:0];
      cur_y_nxt   = start_nxt[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pass_r       <= P_SQ;
      cnt_r        <= '0;
      halted_r     <= 1'b0;
      elapsed_r    <= '0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      start_r      <= '0;
      ctl1_r       <= '0;
      ctl2_r       <= '0;
      end_r        <= '0;
      dur_r        <= DUR_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      cnt_r        <= cnt_nxt;
      halted_r     <= halted_nxt;
      elapsed_r    <= elapsed_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      start_r      <= start_nxt;
      ctl1_r       <= ctl1_nxt;
      ctl2_r       <= ctl2_nxt;
      end_r        <= end_nxt;
      dur_r        <= dur_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    tt_r       <= tt_nxt;
    w1_r       <= w1_nxt;
    w2_r       <= w2_nxt;
    w3_r       <= w3_nxt;
    acc_r      <= acc_nxt;
    mc_r       <= mc_nxt;
    mlt_r      <= mlt_nxt;
    new_x_r    <= new_x_nxt;
    new_y_r    <= new_y_nxt;
    reach_r    <= reach_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // A result past the end of the move never carries a velocity.
  a_reached_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[127:64] == '0))
    else $error("reached result with nonzero velocity");

  // The divider remainder stays below twice the duration.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {dur_eff, 1'b0}))
    else $error("divider remainder out of range");

  // The curve parameter never exceeds one.
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && pass_r == P_SQ) |-> (t_r <= ONE))
    else $error("curve parameter above one");

  // Stop items and items taken while halted start no work.
  a_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser || halted_r)) |=> (state_r == S_IDLE))
    else $error("stop or halted item started a computation");

endmodule

// ===== tb/cubic_bezier_motion_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_motion_step_core_tb
// Drives frame ticks and stop items into the Bezier motion core and compares
// every result with a local fixed-point model or a value given in the script.
// A short scripted table covers reset, extremes, zero duration, stop and halt.
// Random phases then reprogram the path and run ticks paced to the duration.
// The run ends with a tick run without idling at the largest duration.
// ----------------------------------------------------------------------------
module cubic_bezier_motion_step_core_tb;
  import cbms_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned HALF = 64'd1 << (FRAC - 1);
  localparam int SETTLE_CYCLES = 160;
  localparam int RAND_ITEMS = 1100;
  localparam int FINAL_TICKS = 350;
  localparam logic [FT_W-1:0] FT_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_DURATION + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST = '1;

  typedef enum logic {ACT_TICK = 1'b0, ACT_STOP = 1'b1} act_e;
  typedef enum logic {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} row_kind_e;
  typedef enum logic {EXP_PREDICT = 1'b0, EXP_GIVEN = 1'b1} exp_mode_e;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t vx;
    coord_t vy;
    logic   reached;
  } motion_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    cfg_word_t            data;
  } cfg_op_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    cfg_word_t            data;
    act_e                 act;
    logic [FT_W-1:0]      ft;
    exp_mode_e            mode;
    motion_t              given;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cfg_word_t cfg_data = '0;

  // Local copy of the path registers and the motion state.
  cfg_word_t path_start = '0;
  cfg_word_t path_ctl1 = '0;
  cfg_word_t path_ctl2 = '0;
  cfg_word_t path_end = '0;
  dur_t      path_dur = DUR_RESET;
  logic [31:0] elapsed_q16 = '0;
  coord_t cur_x = '0;
  coord_t cur_y = '0;
  bit is_halted = 1'b0;

  motion_t pending_moves[$];
  cfg_op_t staged_writes[$];
  script_row_t script_rows[$];

  int err_count = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;

  cubic_bezier_motion_step_core #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned round_q(longint unsigned v);
    return (v + HALF) >> FRAC;
  endfunction

  function automatic longint axis_offset(longint unsigned w1, w2, w3, coord_t b, c, d);
    longint acc;
    acc = longint'(w1) * longint'($signed(b)) + longint'(w2) * longint'($signed(c))
        + longint'(w3) * longint'($signed(d));
    // Arithmetic shift gives the floor of the signed rounding step.
    return (acc + longint'(HALF)) >>> FRAC;
  endfunction

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
    case (idx)
      REG_START:    path_start = data;
      REG_CTL1:     path_ctl1 = data;
      REG_CTL2:     path_ctl2 = data;
      REG_END:      path_end = data;
      REG_DURATION: path_dur = data[DUR_W-1:0];
      default:      return;
    endcase
    elapsed_q16 = '0;
    is_halted = 1'b0;
    cur_x = path_start[31:0];
    cur_y = path_start[63:32];
  endtask

  task automatic advance_motion(input act_e act, input logic [FT_W-1:0] ft,
                                output bit produced, output motion_t res);
    logic [32:0] tsum;
    longint unsigned dur, t, u, tt, uu, w1, w2, w3;
    longint ox, oy;
    coord_t nx, ny;
    produced = 1'b0;
    res = '0;
    if (is_halted) return;
    if (act == ACT_STOP) begin
      is_halted = 1'b1;
      return;
    end
    tsum = {1'b0, elapsed_q16} + 33'(ft);
    elapsed_q16 = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    dur = (path_dur == '0) ? 64'd1 : 64'(path_dur);
    produced = 1'b1;
    if (64'(elapsed_q16) > dur) begin
      res.px = cur_x;
      res.py = cur_y;
      res.reached = 1'b1;
      return;
    end
    t = (64'(elapsed_q16) << FRAC) / dur;
    if (t > ONE) t = ONE;
    u = ONE - t;
    tt = round_q(t * t);
    uu = round_q(u * u);
    w1 = round_q(3 * t * uu);
    w2 = round_q(3 * tt * u);
    w3 = round_q(tt * t);
    ox = axis_offset(w1, w2, w3, path_ctl1[31:0], path_ctl2[31:0], path_end[31:0]);
    oy = axis_offset(w1, w2, w3, path_ctl1[63:32], path_ctl2[63:32], path_end[63:32]);
    nx = path_start[31:0] + ox[31:0];
    ny = path_start[63:32] + oy[31:0];
    res.px = nx;
    res.py = ny;
    res.vx = nx - cur_x;
    res.vy = ny - cur_y;
    cur_x = nx;
    cur_y = ny;
  endtask

  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(0, 6))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = '0;
      3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    script_rows.push_back(r);
  endfunction

  function automatic void tick_row(input act_e act, input logic [FT_W-1:0] ft);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.act = act;
    r.ft = ft;
    r.mode = EXP_PREDICT;
    script_rows.push_back(r);
  endfunction

  function automatic void lit_row(input logic [FT_W-1:0] ft, input coord_t px, py, vx, vy,
                                  input logic reached);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.act = ACT_TICK;
    r.ft = ft;
    r.mode = EXP_GIVEN;
    r.given = '{px: px, py: py, vx: vx, vy: vy, reached: reached};
    script_rows.push_back(r);
  endfunction

  task automatic stage_write(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
    cfg_op_t op;
    op.idx = idx;
    op.data = data;
    staged_writes.push_back(op);
  endtask

  // Waits until every result is in and the core has had time to finish an
  // item that gives no result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flush_writes();
    cfg_op_t op;
    if (staged_writes.size() == 0) return;
    drain();
    @(negedge clk);
    while (staged_writes.size() != 0) begin
      op = staged_writes.pop_front();
      cfg_we <= 1'b1;
      cfg_index <= op.idx;
      cfg_data <= op.data;
      @(negedge clk);
      load_register(op.idx, op.data);
    end
    cfg_we <= 1'b0;
  endtask

  // Called and returns at a falling edge; valid stays high between items unless a random input gap is drawn.
  task automatic send_item(input act_e act, input logic [FT_W-1:0] ft, input exp_mode_e mode,
                           input motion_t given, output bit live);
    bit produced;
    motion_t res;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= IN_TDATA_W'(ft);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    live = !is_halted;
    advance_motion(act, ft, produced, res);
    if (mode == EXP_GIVEN)
      pending_moves.push_back(given);
    else if (produced)
      pending_moves.push_back(res);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    motion_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_moves.size() == 0) begin
        err_count++;
        $display("%0t: no result expected, got %h reached %b", $time, out_tdata, out_tuser);
      end else begin
        want = pending_moves.pop_front();
        check_field("position_x", want.px, out_tdata[31:0]);
        check_field("position_y", want.py, out_tdata[63:32]);
        check_field("velocity_x", want.vx, out_tdata[95:64]);
        check_field("velocity_y", want.vy, out_tdata[127:96]);
        check_field("reached", 32'(want.reached), 32'(out_tuser));
      end
    end
  end

  initial begin
    #(60_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    script_row_t row;
    bit live;
    int rand_count, run_len, pace, k, sel;
    longint unsigned dur_eff, step_len, ft_val;
    act_e act;
    logic [FT_W-1:0] ft;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset the path is empty and one second long.
    lit_row(20'h00000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    lit_row(FT_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    lit_row(20'h00001, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    cfg_row(REG_START, {32'h0002_0000, 32'hFFFF_8000});
    cfg_row(REG_CTL1, {32'h7FFF_FFFF, 32'h8000_0000});
    cfg_row(REG_CTL2, {32'h8000_0000, 32'h7FFF_FFFF});
    cfg_row(REG_END, {32'h0001_0000, 32'h0003_0000});
    cfg_row(REG_DURATION, {32'hFFFF_FFFF, 32'h0001_0000});
    lit_row(20'h00000, 32'hFFFF_8000, 32'h0002_0000, 32'h0, 32'h0, 1'b0);
    tick_row(ACT_TICK, 20'h04000);
    tick_row(ACT_TICK, 20'h04000);
    tick_row(ACT_TICK, 20'h08000);
    lit_row(20'h00001, 32'h0002_8000, 32'h0003_0000, 32'h0, 32'h0, 1'b1);
    // Stop, then a halted tick and stop; unused indexes must not restart.
    tick_row(ACT_STOP, 20'h00000);
    tick_row(ACT_TICK, 20'h00100);
    tick_row(ACT_STOP, FT_MAX);
    cfg_row(REG_UNUSED_FIRST, 64'h0123_4567_89AB_CDEF);
    cfg_row(REG_UNUSED_LAST, '1);
    tick_row(ACT_TICK, 20'h00100);
    // A zero duration behaves as the smallest one.
    cfg_row(REG_DURATION, 64'h0);
    lit_row(20'h00000, 32'hFFFF_8000, 32'h0002_0000, 32'h0, 32'h0, 1'b0);
    lit_row(20'h00001, 32'h0002_8000, 32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 1'b0);
    lit_row(20'h00000, 32'h0002_8000, 32'h0003_0000, 32'h0, 32'h0, 1'b0);
    lit_row(20'h00001, 32'h0002_8000, 32'h0003_0000, 32'h0, 32'h0, 1'b1);
    cfg_row(REG_DURATION, 64'hFFFF_FFFF);
    tick_row(ACT_TICK, FT_MAX);
    tick_row(ACT_TICK, 20'h7FFFF);
    cfg_row(REG_START, {32'h8000_0000, 32'h7FFF_FFFF});
    cfg_row(REG_END, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    cfg_row(REG_DURATION, 64'h1);
    lit_row(20'h00000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
    lit_row(20'h00001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    lit_row(FT_MAX, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
    cfg_row(REG_DURATION, 64'h8000);
    tick_row(ACT_TICK, 20'h01234);
    tick_row(ACT_TICK, 20'h02000);

    in_gap_pct = 20;
    out_stall_pct = 20;
    foreach (script_rows[i]) begin
      row = script_rows[i];
      if (row.kind == ROW_CFG) begin
        stage_write(row.idx, row.data);
      end else begin
        flush_writes();
        send_item(row.act, row.ft, row.mode, row.given, live);
      end
    end
    flush_writes();

    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      for (int r = 0; r < 5; r++) begin
        if (rand_count == 0 || $urandom_range(0, 99) < 40) begin
          if (r == REG_DURATION) begin
            case ($urandom_range(0, 9))
              0: ft_val = 64'd0;
              1: ft_val = 64'd1;
              2: ft_val = 64'h0000_0000_FFFF_FFFF;
              3: ft_val = 64'($urandom);
              4, 5: ft_val = 64'($urandom_range(2, 32'h0000_FFFF));
              default: ft_val = 64'($urandom_range(32'h0000_8000, 32'h0008_0000));
            endcase
            stage_write(REG_DURATION, {32'($urandom), ft_val[31:0]});
          end else begin
            stage_write(CFG_IDX_W'(r), {rand_coord(), rand_coord()});
          end
        end
      end
      if ($urandom_range(0, 99) < 15)
        stage_write(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                    {32'($urandom), 32'($urandom)});
      if (staged_writes.size() == 0)
        stage_write(REG_UNUSED_LAST, {32'($urandom), 32'($urandom)});
      flush_writes();

      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 8;
        default: in_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 8;
        default: out_stall_pct = 35;
      endcase

      dur_eff = (path_dur == '0) ? 64'd1 : 64'(path_dur);
      pace = $urandom_range(3, 40);
      run_len = $urandom_range(8, 48);
      for (k = 0; k < run_len; k++) begin
        act = ACT_TICK;
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
          act = ACT_STOP;
          ft = FT_W'($urandom_range(0, FT_MAX));
        end else if (sel < 10) begin
          ft = '0;
        end else if (sel < 16) begin
          ft = FT_MAX;
        end else if (sel < 31) begin
          ft = FT_W'($urandom_range(0, FT_MAX));
        end else begin
          // Step sized near the duration divided by pace, capped at the largest frame time.
          step_len = dur_eff / pace;
          if (step_len > FT_MAX) step_len = FT_MAX;
          ft_val = step_len - (step_len >> 3) + $urandom_range(0, 32'(step_len >> 2));
          if (ft_val > FT_MAX) ft_val = FT_MAX;
          ft = ft_val[FT_W-1:0];
        end
        send_item(act, ft, EXP_PREDICT, '0, live);
        if (live) rand_count++;
      end
    end

    // Closing run at the largest duration with full frame steps and no
    // idling on either side.
    stage_write(REG_CTL1, {rand_coord(), rand_coord()});
    stage_write(REG_CTL2, {rand_coord(), rand_coord()});
    stage_write(REG_END, {rand_coord(), rand_coord()});
    stage_write(REG_DURATION, 64'hFFFF_FFFF);
    flush_writes();
    in_gap_pct = 0;
    out_stall_pct = 0;
    for (k = 0; k < FINAL_TICKS; k++)
      send_item(ACT_TICK, FT_MAX, EXP_PREDICT, '0, live);

    drain();
    if (err_count == 0 && pending_moves.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cbms_pkg.sv
rtl/core/cubic_bezier_motion_step_core.sv
tb/cubic_bezier_motion_step_core_tb.sv
